/* rtl/core/linear_probe_hash_table_core_assert.svh */
// Assertion macros for the linear-probe hash table core.
// Used by the top level only; define NO_ASSERTIONS to drop them.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LPH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LPH_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LPH_ASSERT(label, prop, msg)
`define LPH_ASSERT_RST(label, prop, msg)
`endif
`endif

/* rtl/core/lph_pkg.sv */
// Shared types and constants for the linear-probe hash table core.
// No dependencies.
package lph_pkg;
  localparam logic [1:0] FUNC_PUT = 2'd0;
  localparam logic [1:0] FUNC_GET = 2'd1;
  localparam logic [1:0] FUNC_DEL = 2'd2;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam logic [31:0] MIX_MUL = 32'h3243f6a9;
  localparam logic [8:0] COUNT_MAX = 9'd511;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] hash;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] read_value;
    logic [7:0]  slot;
    logic [8:0]  entry_total;
  } rsp_t;
endpackage

/* rtl/core/lph_if.sv */
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface lph_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/lph_front.sv */
// Front end: normalises the key and computes the mixed djb2 hash over cycles.
// Depends on lph_pkg.
module lph_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [31:0]         key_i,
  input  logic [31:0]         value_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output lph_pkg::req_t       q_data_o
);
  typedef enum logic [2:0] {S_IDLE, S_DJB, S_MIX1, S_MIX2, S_OUT} state_e;
  state_e      state_q;
  logic [1:0]  func_q;
  logic [31:0] key_q, value_q, h_q, m_q;
  logic [31:0] nkey;

  always_comb begin
    nkey = '0;
    if (key_i[7:0] != 8'd0) begin
      nkey[7:0] = key_i[7:0];
      if (key_i[15:8] != 8'd0) begin
        nkey[15:8] = key_i[15:8];
        if (key_i[23:16] != 8'd0) begin
          nkey[23:16] = key_i[23:16];
          if (key_i[31:24] != 8'd0) nkey[31:24] = key_i[31:24];
        end
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign q_valid_o  = (state_q == S_OUT);
  assign q_data_o   = '{func: func_q, key: key_q, value: value_q, hash: h_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q <= '0; key_q <= '0; value_q <= '0; h_q <= '0; m_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q <= func_i; key_q <= nkey; value_q <= value_i;
            h_q <= lph_pkg::HASH_SEED; m_q <= nkey;
            state_q <= S_DJB;
          end
        end
        S_DJB: begin
          if (m_q[7:0] != 8'd0) begin
            h_q <= (h_q << 5) + h_q + {24'd0, m_q[7:0]};
            m_q <= m_q >> 8;
          end else begin
            h_q <= h_q ^ (h_q >> 16);
            state_q <= S_MIX1;
          end
        end
        S_MIX1: begin
          h_q <= h_q * lph_pkg::MIX_MUL;
          state_q <= S_MIX2;
        end
        S_MIX2: begin
          h_q <= h_q ^ (h_q >> 16);
          state_q <= S_OUT;
        end
        S_OUT: if (q_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/lph_fifo.sv */
// Two-entry queue between front and back end.
// Depends on lph_pkg.
module lph_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          w_valid_i,
  output logic          w_ready_o,
  input  lph_pkg::req_t w_data_i,
  output logic          r_valid_o,
  input  logic          r_ready_i,
  output lph_pkg::req_t r_data_o
);
  lph_pkg::req_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign w_ready_o = (cnt_q != 2'd2);
  assign r_valid_o = (cnt_q != 2'd0);
  assign r_data_o  = mem_q[rp_q];
  assign wr = w_valid_i && w_ready_o;
  assign rd = r_valid_o && r_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= w_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

/* rtl/core/lph_back.sv */
// Back end: home-slot modulo, probe walk over the slot memories, update, result.
// Depends on lph_pkg.
module lph_back #(
  parameter int unsigned TableDepth = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [8:0]    capacity_i,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  lph_pkg::req_t q_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lph_pkg::rsp_t out_data_o
);
  localparam int unsigned AW = (TableDepth > 2) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned HW = 32 + CW;

  typedef enum logic [2:0] {S_IDLE, S_MOD, S_RD, S_CHK, S_OUT} state_e;
  state_e state_q;

  logic [TableDepth-1:0] used_q, dead_q;
  logic [31:0] hash_mem [TableDepth];
  logic [31:0] key_mem  [TableDepth];
  logic [31:0] val_mem  [TableDepth];

  lph_pkg::req_t req_q;
  logic [CW-1:0] cap_q, n_q;
  logic [AW-1:0] idx_q, home_q;
  logic [HW-1:0] rem_q;
  logic [5:0]    bit_q;
  logic [31:0]   rd_hash_q, rd_key_q, rd_val_q;
  logic          rd_used_q, rd_dead_q;
  logic [8:0]    live_q;
  lph_pkg::rsp_t rsp_q;

  logic [CW-1:0] cap_c, cap_ext;
  logic [HW-1:0] sub_c;
  logic [AW-1:0] idx_nx;

  function automatic logic q_dummy_bit(input logic [31:0] h, input logic [5:0] b);
    q_dummy_bit = h[b[4:0]];
  endfunction

  always_comb begin
    cap_ext = (CW > 9) ? CW'(capacity_i) : capacity_i[CW-1:0];
    if (capacity_i == 9'd0) cap_c = CW'(1);
    else if ({23'd0, capacity_i} > 32'(TableDepth)) cap_c = CW'(TableDepth);
    else cap_c = cap_ext;
    sub_c  = {rem_q[HW-2:0], 1'b0} | HW'(q_dummy_bit(req_q.hash, bit_q));
    idx_nx = ({1'b0, idx_q} + CW'(1) >= cap_q) ? '0 : idx_q + AW'(1);
  end

  assign q_ready_o   = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rd_hash_q <= hash_mem[idx_q];
      rd_key_q  <= key_mem[idx_q];
      rd_val_q  <= val_mem[idx_q];
    end
    if (state_q == S_CHK && req_q.func == lph_pkg::FUNC_PUT &&
        (!rd_used_q || rd_dead_q ||
         (rd_hash_q == req_q.hash && rd_key_q == req_q.key))) begin
      hash_mem[idx_q] <= req_q.hash;
      key_mem[idx_q]  <= req_q.key;
      val_mem[idx_q]  <= req_q.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0; dead_q <= '0; live_q <= '0;
      req_q <= '0; cap_q <= '0; n_q <= '0; idx_q <= '0; home_q <= '0;
      rem_q <= '0; bit_q <= '0; rd_used_q <= 1'b0; rd_dead_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            req_q <= q_data_i;
            cap_q <= cap_c;
            rem_q <= '0;
            bit_q <= 6'd31;
            if (q_data_i.func == lph_pkg::FUNC_NOP) begin
              rsp_q <= '{status: lph_pkg::ST_DONE, found: 1'b0, read_value: '0,
                         slot: '0, entry_total: live_q};
              state_q <= S_OUT;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_MOD: begin
          // restoring remainder, one hash bit a cycle
          if (sub_c >= HW'(cap_q)) rem_q <= sub_c - HW'(cap_q);
          else rem_q <= sub_c;
          if (bit_q == 6'd0) state_q <= S_RD;
          else bit_q <= bit_q - 6'd1;
          if (bit_q == 6'd0) begin
            idx_q  <= (sub_c >= HW'(cap_q)) ? AW'(sub_c - HW'(cap_q)) : AW'(sub_c);
            home_q <= (sub_c >= HW'(cap_q)) ? AW'(sub_c - HW'(cap_q)) : AW'(sub_c);
            n_q <= '0;
          end
        end
        S_RD: begin
          rd_used_q <= used_q[idx_q];
          rd_dead_q <= dead_q[idx_q];
          state_q <= S_CHK;
        end
        S_CHK: begin
          logic hit, stop, empty, tomb;
          empty = !rd_used_q;
          tomb  = rd_used_q && rd_dead_q;
          hit   = rd_used_q && !rd_dead_q && rd_hash_q == req_q.hash && rd_key_q == req_q.key;
          stop  = empty || hit || (tomb && req_q.func == lph_pkg::FUNC_PUT);
          if (stop) begin
            rsp_q.slot <= 8'(idx_q);
            rsp_q.found <= hit;
            rsp_q.read_value <= '0;
            rsp_q.status <= lph_pkg::ST_DONE;
            rsp_q.entry_total <= live_q;
            if (req_q.func == lph_pkg::FUNC_PUT) begin
              used_q[idx_q] <= 1'b1;
              dead_q[idx_q] <= 1'b0;
              if (!hit && live_q != lph_pkg::COUNT_MAX) begin
                live_q <= live_q + 9'd1;
                rsp_q.entry_total <= live_q + 9'd1;
              end
            end else if (!hit) begin
              rsp_q.status <= lph_pkg::ST_MISS;
            end else if (req_q.func == lph_pkg::FUNC_GET) begin
              rsp_q.read_value <= rd_val_q;
            end else begin
              dead_q[idx_q] <= 1'b1;
              if (live_q != 9'd0) begin
                live_q <= live_q - 9'd1;
                rsp_q.entry_total <= live_q - 9'd1;
              end
            end
            state_q <= S_OUT;
          end else if (n_q + CW'(1) >= cap_q) begin
            rsp_q.slot <= 8'(home_q);
            rsp_q.found <= 1'b0;
            rsp_q.read_value <= '0;
            rsp_q.status <= (req_q.func == lph_pkg::FUNC_PUT) ? lph_pkg::ST_FULL
                                                              : lph_pkg::ST_MISS;
            rsp_q.entry_total <= live_q;
            state_q <= S_OUT;
          end else begin
            n_q <= n_q + CW'(1);
            idx_q <= idx_nx;
            state_q <= S_RD;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/linear_probe_hash_table_core.sv */
// Linear-probe hash table core: put/get/delete of 32-bit keys and values.
// Path from input beat to result: key hash in the front end, hand-over through the queue,
// home-slot modulo, then a read and a check state for each probe.
// The back end works on one request at a time; the front end overlaps it with the next.
// Reset clears all used/dead bits and the live count; capacity resets to 256.
// Depends on lph_pkg, lph_if, lph_front, lph_fifo, lph_back.
`include "linear_probe_hash_table_core_assert.svh"
module linear_probe_hash_table_core #(
  parameter int unsigned TableDepth = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  lph_if.sink   in_if,
  lph_if.source out_if
);
  logic [8:0] cap_q;
  logic f_valid, f_ready, b_valid, b_ready;
  lph_pkg::req_t f_data, b_data;
  lph_pkg::rsp_t rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 9'd256;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  lph_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .func_i(in_if.data.func), .key_i(in_if.data.key), .value_i(in_if.data.value),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_data_o(f_data)
  );

  lph_fifo u_fifo (
    .clk_i, .rst_ni,
    .w_valid_i(f_valid), .w_ready_o(f_ready), .w_data_i(f_data),
    .r_valid_o(b_valid), .r_ready_i(b_ready), .r_data_o(b_data)
  );

  lph_back #(.TableDepth(TableDepth)) u_back (
    .clk_i, .rst_ni, .capacity_i(cap_q),
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_data_i(b_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(rsp)
  );

  assign out_if.data = rsp;

  `LPH_ASSERT(a_status_ok, out_if.valid |-> rsp.status != 2'd3, "bad status")
  `LPH_ASSERT(a_rval_get, (out_if.valid && rsp.read_value != 32'd0) |-> rsp.found, "rval w/o hit")
  `LPH_ASSERT(a_out_hold, (out_if.valid && !out_if.ready) |=> $stable(rsp), "beat changed")
endmodule

/* sim/lph_checker.sv */
// Scoreboard for the linear-probe hash table core: watches both channels and the capacity port,
// keeps its own copy of the table, and compares every response beat with the predicted one.
// Depends on lph_pkg.
module lph_checker
  import lph_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       req_valid_i,
  input  logic       req_ready_i,
  input  req_t       req_i,
  input  logic       rsp_valid_i,
  input  logic       rsp_ready_i,
  input  rsp_t       rsp_i,
  output int         errors_o,
  output int         pending_o,
  output int         full_seen_o,
  output int         hit_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 256;

  logic        slot_live[Depth];
  logic        slot_tomb[Depth];
  logic [31:0] slot_hash[Depth];
  logic [31:0] slot_key[Depth];
  logic [31:0] slot_val[Depth];
  logic [8:0]  live_cnt;
  logic [8:0]  capacity;
  rsp_t        pending_rsp_q[$];

  function automatic logic [31:0] trim_key(logic [31:0] k);
    logic [31:0] t;
    logic        stop;
    t = '0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) t[8*i +: 8] = k[8*i +: 8];
    end
    return t;
  endfunction

  function automatic logic [31:0] key_digest(logic [31:0] k);
    logic [31:0] h;
    logic        stop;
    h = HASH_SEED;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) h = (h << 5) + h + {24'd0, k[8*i +: 8]};
    end
    h = h ^ (h >> 16);
    h = h * MIX_MUL;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Applies one request to the model table and returns the response it should give.
  function automatic rsp_t table_access(req_t r);
    rsp_t        o;
    int unsigned cap;
    int unsigned idx;
    logic [31:0] k;
    logic [31:0] h;
    int          kind;
    o = '0;
    if (r.func > FUNC_DEL) begin
      o.entry_total = live_cnt;
      return o;
    end
    cap = (capacity == 0) ? 1 : (capacity > Depth) ? Depth : capacity;
    k = trim_key(r.key);
    h = key_digest(k);
    idx = h % cap;
    kind = 0;
    for (int n = 0; n < cap && kind == 0; n++) begin
      if (!slot_live[idx]) kind = 1;
      else if (slot_tomb[idx]) begin
        if (r.func == FUNC_PUT) kind = 2;
      end else if (slot_hash[idx] == h && slot_key[idx] == k) kind = 3;
      if (kind == 0) idx = (idx + 1 >= cap) ? 0 : idx + 1;
    end
    o.slot = idx[7:0];
    if (r.func == FUNC_PUT) begin
      if (kind == 0) o.status = ST_FULL;
      else begin
        if (kind == 3) o.found = 1'b1;
        else if (live_cnt < COUNT_MAX) live_cnt++;
        slot_live[idx] = 1'b1;
        slot_tomb[idx] = 1'b0;
        slot_hash[idx] = h;
        slot_key[idx] = k;
        slot_val[idx] = r.value;
      end
    end else if (kind != 3) o.status = ST_MISS;
    else begin
      o.found = 1'b1;
      if (r.func == FUNC_GET) o.read_value = slot_val[idx];
      else begin
        slot_tomb[idx] = 1'b1;
        if (live_cnt > 0) live_cnt--;
      end
    end
    o.entry_total = live_cnt;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        slot_live[i] = 1'b0;
        slot_tomb[i] = 1'b0;
      end
      live_cnt = '0;
      capacity = 9'd256;
      pending_rsp_q.delete();
      errors_o = 0;
      full_seen_o = 0;
      hit_seen_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response beat with nothing outstanding");
          errors_o++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, rsp_i.status);
            errors_o++;
          end
          if (rsp_i.found !== want.found) begin
            $error("found exp %0d got %0d", want.found, rsp_i.found);
            errors_o++;
          end
          if (rsp_i.read_value !== want.read_value) begin
            $error("read_value exp %h got %h", want.read_value, rsp_i.read_value);
            errors_o++;
          end
          if (rsp_i.slot !== want.slot) begin
            $error("slot exp %0d got %0d", want.slot, rsp_i.slot);
            errors_o++;
          end
          if (rsp_i.entry_total !== want.entry_total) begin
            $error("entry_total exp %0d got %0d", want.entry_total, rsp_i.entry_total);
            errors_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = table_access(req_i);
        if (want.status == ST_FULL) full_seen_o++;
        if (want.found) hit_seen_o++;
        pending_rsp_q.push_back(want);
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
    end
    pending_o = pending_rsp_q.size();
  end
endmodule

/* sim/tb_top.sv */
// Top of the hash table core testbench: clock, reset, capacity writes and request stimulus
// with random gaps and stalls; checking is left to lph_checker. Prints the verdict.
// Depends on lph_pkg, lph_if, linear_probe_hash_table_core, lph_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lph_pkg::*;

  localparam longint CycleLimit = 8000000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  logic       quiet;
  int         errors, pending, full_seen, hit_seen, sent;
  longint     cycles;
  logic [31:0] key_pool[$];

  lph_if #(.T(req_t)) req_ch (clk_i);
  lph_if #(.T(rsp_t)) rsp_ch (clk_i);

  linear_probe_hash_table_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (req_ch.sink),
    .out_if      (rsp_ch.source)
  );

  lph_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_ch.valid),
    .req_ready_i (req_ch.ready),
    .req_i       (req_ch.data),
    .rsp_valid_i (rsp_ch.valid),
    .rsp_ready_i (rsp_ch.ready),
    .rsp_i       (rsp_ch.data),
    .errors_o    (errors),
    .pending_o   (pending),
    .full_seen_o (full_seen),
    .hit_seen_o  (hit_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[linear_probe_hash_table_core] ERROR");
      $finish;
    end
  end

  // Response side: random stall before each beat.
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
    end
  end

  task automatic send_req(logic [1:0] func, logic [31:0] key, logic [31:0] value);
    int n;
    n = quiet ? 0 : $urandom_range(0, 19);
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{func: func, key: key, value: value, hash: 32'd0};
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [8:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_key();
    logic [31:0] k;
    k = $urandom;
    for (int i = 0; i < 4; i++)
      if ($urandom_range(0, 6) == 0) k[8*i +: 8] = 8'd0;
    return k;
  endfunction

  task automatic run_phase(int items, int pool_size, bit hold_mid);
    logic [1:0]  func;
    logic [31:0] key;
    int          r;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back(rand_key());
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (hold_mid && i == items / 2) drain();
      r = $urandom_range(0, 99);
      func = (r < 45) ? FUNC_PUT : (r < 75) ? FUNC_GET : (r < 95) ? FUNC_DEL : FUNC_NOP;
      key = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
      send_req(func, key, $urandom);
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    logic [8:0] caps[9] = '{9'd1, 9'd0, 9'd5, 9'd300, 9'd2, 9'd37, 9'd511, 9'd16, 9'd256};
    int pool;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet = 1'b0;
    cycles = 0;
    sent = 0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty key, all-ones, overwrite, tombstone reuse, trimmed keys, no-op
    send_req(FUNC_GET, 32'h0000_0000, 32'h0);
    send_req(FUNC_DEL, 32'h0000_0000, 32'h0);
    send_req(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(FUNC_GET, 32'hFF00_0000, 32'h0);
    send_req(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(FUNC_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_req(FUNC_PUT, 32'h00AB_0061, 32'hA5A5_A5A5);
    send_req(FUNC_GET, 32'h0000_0061, 32'h0);
    send_req(FUNC_DEL, 32'h7700_0061, 32'h0);
    send_req(FUNC_GET, 32'h0000_0061, 32'h0);
    send_req(FUNC_DEL, 32'h0000_0061, 32'h0);
    send_req(FUNC_PUT, 32'h0000_0061, 32'h5A5A_5A5A);
    send_req(FUNC_GET, 32'h0000_0061, 32'h0);
    send_req(FUNC_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(FUNC_DEL, 32'hFFFF_FFFF, 32'h0);
    send_req(FUNC_DEL, 32'h0000_0000, 32'h0);
    send_req(FUNC_GET, 32'h0102_0304, 32'h0);
    drain();

    foreach (caps[i]) begin
      set_capacity(caps[i]);
      pool = (caps[i] == 0) ? 3 : (caps[i] > 40) ? 48 : caps[i] + 6;
      run_phase(200, pool, i == 3);
    end

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d requests at the reset capacity and 9 written ones: %0d hits, %0d full puts.",
             sent, hit_seen, full_seen);
    if (errors == 0) $display("[linear_probe_hash_table_core] OK");
    else $display("[linear_probe_hash_table_core] ERROR");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lph_pkg.sv
rtl/core/lph_if.sv
rtl/core/lph_front.sv
rtl/core/lph_fifo.sv
rtl/core/lph_back.sv
rtl/core/linear_probe_hash_table_core.sv
sim/lph_checker.sv
sim/tb_top.sv
